// File: hdl/kbrz_pkg.sv
// ----------------------------------------------------------------------------
// kbrz_pkg
// Shared types, constants and helpers for the keypad backlight ramp
// controller.
// ----------------------------------------------------------------------------
package kbrz_pkg;

  localparam int ZONE_COUNT = 6;

  localparam logic [23:0] ZONE_TABLE_RESET = 24'h555552;
  localparam logic [15:0] STEP_TICKS_RESET = 16'd50;
  localparam logic        ALT_MODE_RESET   = 1'b0;
  localparam logic [15:0] BOOST_RESET      = 16'd4100;
  localparam logic [2:0]  ZONE_RESET       = 3'd5;
  localparam logic [15:0] TICK_MAX         = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_USER = 2'd0,
    OP_ZONE = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_ZONE_TABLE = 2'd0,
    REG_STEP_TICKS = 2'd1,
    REG_ALT_MODE   = 2'd2,
    REG_BOOST      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [23:0] zone_table;
    logic [15:0] step_ticks;
    logic        alt_mode;
    logic [15:0] boost_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] user_level;
    logic [2:0] new_zone;
    logic [2:0] previous_zone;
  } in_item_t;

  // zones past the table read level 0
  function automatic logic [3:0] zone_level(input logic [23:0] tbl, input logic [2:0] zone);
    logic [31:0] ext;
    ext = {8'h00, tbl};
    return ext[{zone, 2'b00} +: 4];
  endfunction

endpackage

// File: hdl/kbrz_if.sv
// ----------------------------------------------------------------------------
// kbrz_in_if / kbrz_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface kbrz_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] user_level;
  logic [2:0] new_zone;
  logic [2:0] previous_zone;

  modport source (output valid, operation, user_level, new_zone, previous_zone,
                  input ready);
  modport sink (input valid, operation, user_level, new_zone, previous_zone,
                output ready);
endinterface

interface kbrz_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  led_level;
  logic        boost_on;
  logic [15:0] boost_out;
  logic        ramping;
  logic        status;

  modport source (output valid, led_level, boost_on, boost_out, ramping, status,
                  input ready);
  modport sink (input valid, led_level, boost_on, boost_out, ramping, status,
                output ready);
endinterface

// File: hdl/kbrz_in_stage.sv
// ----------------------------------------------------------------------------
// kbrz_in_stage
// Input register: holds one request item until the core takes it.
// ----------------------------------------------------------------------------
module kbrz_in_stage
  import kbrz_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  kbrz_in_if.sink  in_ch,
  input  logic     take,
  output logic     item_valid,
  output in_item_t item
);

  logic load;

  assign in_ch.ready = !item_valid || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.operation     <= in_ch.operation;
      item.user_level    <= in_ch.user_level;
      item.new_zone      <= in_ch.new_zone;
      item.previous_zone <= in_ch.previous_zone;
    end
  end

endmodule

// File: hdl/kbrz_core.sv
// ----------------------------------------------------------------------------
// kbrz_core
// Backlight state, per-item update logic and the result register.
// ----------------------------------------------------------------------------
module kbrz_core
  import kbrz_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       item_valid,
  input  in_item_t   item,
  output logic       take,
  kbrz_out_if.source out_ch
);

  logic [3:0]  level_now, level_now_next;
  logic [3:0]  level_target, level_target_next;
  logic [7:0]  user_lvl, user_lvl_next;
  logic [2:0]  zone_now, zone_now_next;
  logic [15:0] tick_count, tick_count_next;
  logic        boost_enabled, boost_enabled_next;
  logic        status_next;
  logic        take_new;
  logic [3:0]  new_target;
  logic [3:0]  zlvl;
  logic [15:0] tick_inc;

  assign take = item_valid && (!out_ch.valid || out_ch.ready);
  assign zlvl = zone_level(cfg.zone_table, item.new_zone);
  assign tick_inc = (tick_count != TICK_MAX) ? tick_count + 16'd1 : tick_count;

  always_comb begin
    level_now_next     = level_now;
    level_target_next  = level_target;
    user_lvl_next      = user_lvl;
    zone_now_next      = zone_now;
    tick_count_next    = tick_count;
    boost_enabled_next = boost_enabled;
    status_next        = 1'b0;
    take_new           = 1'b0;
    new_target         = 4'd0;
    unique case (op_t'(item.operation))
      OP_USER: begin
        user_lvl_next = item.user_level;
        take_new      = 1'b1;
        new_target = (item.user_level != 8'd0) ? zone_level(cfg.zone_table, zone_now) : 4'd0;
      end
      OP_ZONE: begin
        if ({1'b0, item.new_zone} >= 4'(ZONE_COUNT)) begin
          status_next = 1'b1;
        end else begin
          if (zlvl == 4'd0) begin
            take_new = 1'b1;
          end else if (user_lvl != 8'd0 &&
                       (cfg.alt_mode || item.new_zone > item.previous_zone)) begin
            take_new   = 1'b1;
            new_target = zlvl;
          end
          zone_now_next = item.new_zone;
        end
      end
      OP_TICK: begin
        if (level_now != level_target) begin
          tick_count_next = tick_inc;
          if (tick_inc >= cfg.step_ticks) begin
            level_now_next  = (level_now < level_target) ? level_now + 4'd1
                                                         : level_now - 4'd1;
            tick_count_next = 16'd0;
          end
        end else begin
          tick_count_next = 16'd0;
        end
      end
      default: begin
      end
    endcase
    if (take_new) begin
      level_target_next  = new_target;
      tick_count_next    = 16'd0;
      boost_enabled_next = (new_target != 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_now     <= 4'd0;
      level_target  <= 4'd0;
      user_lvl      <= 8'd0;
      zone_now      <= ZONE_RESET;
      tick_count    <= 16'd0;
      boost_enabled <= 1'b0;
    end else if (take) begin
      level_now     <= level_now_next;
      level_target  <= level_target_next;
      user_lvl      <= user_lvl_next;
      zone_now      <= zone_now_next;
      tick_count    <= tick_count_next;
      boost_enabled <= boost_enabled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (take) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_ch.led_level <= level_now_next;
      out_ch.boost_on  <= boost_enabled_next;
      out_ch.boost_out <= boost_enabled_next ? cfg.boost_level : 16'd0;
      out_ch.ramping   <= (level_now_next != level_target_next);
      out_ch.status    <= status_next;
    end
  end

endmodule

// File: hdl/keypad_backlight_ramp_zone_ctrl_top.sv
// ----------------------------------------------------------------------------
// keypad_backlight_ramp_zone_ctrl_top
// Keypad backlight controller with ambient zones and a timed ramp.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries request items: user brightness request, ambient zone
//   change, or millisecond tick. out_ch returns exactly one result item per
//   request: LED level, boost enable and level, ramp flag and status.
//   cfg_wr_en/cfg_index/cfg_data write the four settings registers; write
//   them only while no item is in flight.
// Timing:
//   An item accepted from in_ch sits in the input register, is evaluated and
//   lands in the result register when the core takes it; the take waits
//   while a held result is not yet accepted. One item is taken per cycle
//   unless out_ch stalls; the state update is a single registered pass.
// Reset:
//   rst (synchronous) clears both stages, sets the level and target to 0,
//   the zone to 5 and restores the settings registers to their defaults.
// Stall:
//   While out_ch.ready is low, the result register holds and the input
//   register still takes one more item; then in_ch.ready drops.
// ----------------------------------------------------------------------------
module keypad_backlight_ramp_zone_ctrl_top
  import kbrz_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  kbrz_in_if.sink     in_ch,
  kbrz_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_t     cfg;
  logic     item_valid;
  in_item_t item;
  logic     take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zone_table  <= ZONE_TABLE_RESET;
      cfg.step_ticks  <= STEP_TICKS_RESET;
      cfg.alt_mode    <= ALT_MODE_RESET;
      cfg.boost_level <= BOOST_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ZONE_TABLE: cfg.zone_table  <= cfg_data;
        REG_STEP_TICKS: cfg.step_ticks  <= cfg_data[15:0];
        REG_ALT_MODE:   cfg.alt_mode    <= cfg_data[0];
        REG_BOOST:      cfg.boost_level <= cfg_data[15:0];
      endcase
    end
  end

  kbrz_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  kbrz_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_ch     (out_ch)
  );

  a_boost_off_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.boost_on |-> out_ch.boost_out == 16'd0)
    else $error("boost level driven while boost is off");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_ch.valid && !item_valid)
    else $error("pipeline not empty after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    item_valid && out_ch.valid && !out_ch.ready |-> !in_ch.ready && !take)
    else $error("item taken while both stages are held");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> out_ch.valid)
    else $error("taken item produced no result");

endmodule
